// ===== hw/rtl/tsht_pkg.sv =====
`default_nettype none
// Shared types and codes for the timestamp-sorted handle table.
// No dependencies; the sequencer, the top level and the bench import this package.
package tsht_pkg;

   // Field widths of the stored entry and the response, and the default table depth
   localparam int HANDLE_BITS     = 16;
   localparam int STAMP_BITS      = 32;
   localparam int TAG_BITS        = 32;
   localparam int TOTAL_BITS      = 5;
   localparam int TABLE_DEPTH_DEF = 16;

   // Operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [1:0]             op;
      logic [HANDLE_BITS-1:0] handle;
      logic [31:0]            stamp;
      logic [31:0]            name_tag;
   } tsht_req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] found_handle;
      logic [TOTAL_BITS-1:0]  entry_total;
   } tsht_rsp_type;

   // One table slot as held in memory
   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [STAMP_BITS-1:0]  stamp;
      logic [TAG_BITS-1:0]    tag;
   } tsht_entry_type;

   // Finished result handed from the sequencer to the output register
   typedef struct packed {
      logic         valid;
      tsht_rsp_type rsp;
   } tsht_res_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tsht_ram.sv =====
`default_nettype none
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tsht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tsht_seq.sv =====
`default_nettype none
// Sequencer of the handle table: walks the slot memory one entry per cycle,
// shifting entries for insert and delete. Depends on tsht_pkg and tsht_ram.
module tsht_seq #(
   parameter int TABLE_DEPTH = tsht_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire tsht_pkg::tsht_req_type req_payload,
   output logic                       req_stall,
   output tsht_pkg::tsht_res_type     res,
   input  wire logic                  res_take
);
   import tsht_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = $bits(tsht_entry_type);

   localparam logic [IW-1:0] IDX_ONE    = IW'(1);
   localparam logic [IW-1:0] IDX_ZERO   = '0;
   localparam logic [CW-1:0] CNT_ONE    = CW'(1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_WALK  = 2'd1;
   localparam logic [1:0] S_PLACE = 2'd2;
   localparam logic [1:0] S_REPLY = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic                   found_ff, found_in;
   tsht_req_type           cur_ff, cur_in;
   logic [1:0]             status_ff, status_in;
   logic [HANDLE_BITS-1:0] hit_ff, hit_in;

   logic                   wr_en, rd_en;
   logic [IW-1:0]          wr_addr, rd_addr;
   logic [EW-1:0]          wr_data, rd_data;
   tsht_entry_type         ent, cur_ent, req_ent;
   logic [CW-1:0]          count_m1;
   logic [IW-1:0]          last_idx;
   logic [CW+TOTAL_BITS-1:0] total_wide;

   assign ent      = tsht_entry_type'(rd_data);
   assign cur_ent  = '{handle: cur_ff.handle,
                       stamp:  cur_ff.stamp[STAMP_BITS-1:0],
                       tag:    cur_ff.name_tag[TAG_BITS-1:0]};
   assign req_ent  = '{handle: req_payload.handle,
                       stamp:  req_payload.stamp[STAMP_BITS-1:0],
                       tag:    req_payload.name_tag[TAG_BITS-1:0]};
   assign count_m1 = count_ff - CNT_ONE;
   assign last_idx = count_m1[IW-1:0];

   tsht_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequence one request: start, walk the slots when the op needs it, reply
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      cur_in    = cur_ff;
      status_in = status_ff;
      hit_in    = hit_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff + IDX_ONE;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_in    = req_payload;
               found_in  = 1'b0;
               hit_in    = '0;
               status_in = ST_MISS;
               state_in  = S_REPLY;
               case (req_payload.op)
                  OP_INSERT: begin
                     if (count_ff == FULL_COUNT) begin
                        status_in = ST_FULL;
                     end else if (count_ff == '0) begin
                        // empty table: place directly in the first slot
                        wr_en     = 1'b1;
                        wr_addr   = IDX_ZERO;
                        wr_data   = req_ent;
                        count_in  = CNT_ONE;
                        status_in = ST_OK;
                     end else begin
                        // walk from the tail toward the head
                        rd_en    = 1'b1;
                        rd_addr  = last_idx;
                        idx_in   = last_idx;
                        state_in = S_WALK;
                     end
                  end
                  OP_DELETE, OP_LOOKUP: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_ZERO;
                        idx_in   = IDX_ZERO;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     status_in = ST_MISS;
                  end
               endcase
            end
         end

         S_WALK: begin
            case (cur_ff.op)
               OP_INSERT: begin
                  wr_en = 1'b1;
                  if (ent.stamp >= cur_ent.stamp) begin
                     // insertion point found: new entry lands behind this one
                     wr_data   = cur_ent;
                     count_in  = count_ff + CNT_ONE;
                     status_in = ST_OK;
                     state_in  = S_REPLY;
                  end else if (idx_ff == IDX_ZERO) begin
                     // shift the head down, new entry goes to slot zero
                     state_in = S_PLACE;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = idx_ff - IDX_ONE;
                     idx_in  = idx_ff - IDX_ONE;
                  end
               end
               OP_DELETE: begin
                  // after the match, pull each entry up by one slot
                  if (found_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = idx_ff - IDX_ONE;
                  end
                  found_in = found_ff || (ent.handle == cur_ff.handle);
                  if (idx_ff == last_idx) begin
                     if (found_in) begin
                        count_in  = count_m1;
                        status_in = ST_OK;
                     end
                     state_in = S_REPLY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = idx_ff + IDX_ONE;
                     idx_in  = idx_ff + IDX_ONE;
                  end
               end
               OP_LOOKUP: begin
                  if (ent.tag == cur_ent.tag) begin
                     status_in = ST_OK;
                     hit_in    = ent.handle;
                     state_in  = S_REPLY;
                  end else if (idx_ff == last_idx) begin
                     state_in = S_REPLY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = idx_ff + IDX_ONE;
                     idx_in  = idx_ff + IDX_ONE;
                  end
               end
               default: begin
                  state_in = S_REPLY;
               end
            endcase
         end

         S_PLACE: begin
            wr_en     = 1'b1;
            wr_addr   = IDX_ZERO;
            wr_data   = cur_ent;
            count_in  = count_ff + CNT_ONE;
            status_in = ST_OK;
            state_in  = S_REPLY;
         end

         S_REPLY: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      found_ff  <= found_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign total_wide = {{TOTAL_BITS{1'b0}}, count_ff};

   assign res.valid            = (state_ff == S_REPLY);
   assign res.rsp.status       = status_ff;
   assign res.rsp.found_handle = hit_ff;
   assign res.rsp.entry_total  = total_wide[TOTAL_BITS-1:0];

`ifndef SYNTHESIS
   // Fill count never passes the table depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("fill count beyond table depth");

   // A shift never reads the slot it writes in the same cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write hit the same slot");

   // Fill count moves only when an operation finishes
   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> (state_ff == S_REPLY))
      else $error("fill count changed outside completion");

   // No slot write while a result is waiting
   a_quiet_reply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY) |-> !wr_en)
      else $error("slot write during reply");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/timestamp_sorted_handle_table_core.sv =====
`default_nettype none
// Top level of the timestamp-sorted handle table: sequencer plus output register.
// Depends on tsht_pkg and tsht_seq.
//
//   channel  ports                                  direction
//   request  req_valid, req_stall, req_payload      in  (op, handle, stamp, name_tag)
//   response rsp_valid, rsp_stall, rsp_payload      out (status, found_handle, entry_total)
//
// Insert, delete and lookup walk the held entries: the walk visits one slot per cycle
// through the single memory read port. One request is in work at a time; the next is
// taken while the previous result waits in the output register. Reset clears the state,
// the fill count and the output valid, not the slot contents; slots are never read
// before written. A stalled response holds the sequencer in reply.
module timestamp_sorted_handle_table_core #(
   parameter int TABLE_DEPTH = tsht_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tsht_pkg::tsht_req_type req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tsht_pkg::tsht_rsp_type     rsp_payload
);
   import tsht_pkg::*;

   tsht_res_type res;
   logic         res_take;
   logic         slot_free;
   logic         rsp_valid_ff, rsp_valid_in;
   tsht_rsp_type rsp_payload_ff, rsp_payload_in;

   tsht_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .res         (res),
      .res_take    (res_take)
   );

   // Load the output register when it is empty or being drained
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign res_take  = res.valid && slot_free;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_take) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res.rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

// ===== bench/timestamp_sorted_handle_table_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for timestamp_sorted_handle_table_core: a software copy of the
// newest-first handle table predicts every response. Depends on tsht_pkg and the core.
module timestamp_sorted_handle_table_core_tb;
   import tsht_pkg::*;

   localparam int         TBL_DEPTH   = TABLE_DEPTH_DEF;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         REPORT_MAX  = 10;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   tsht_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   tsht_rsp_type rsp_payload;

   // Shadow copy of the table, newest stamp first
   logic [HANDLE_BITS-1:0] tbl_handle [TBL_DEPTH];
   logic [STAMP_BITS-1:0]  tbl_stamp  [TBL_DEPTH];
   logic [TAG_BITS-1:0]    tbl_tag    [TBL_DEPTH];
   int                     tbl_fill = 0;

   tsht_rsp_type pending_rsp [$];
   int           fail_count    = 0;
   int           request_count = 0;
   int           ok_count      = 0;
   int           full_count    = 0;
   int           miss_count    = 0;
   int           stall_left    = 0;
   bit           idle_on       = 1'b1;

   timestamp_sorted_handle_table_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   // Apply one request to the shadow table and return the response it must produce
   function automatic tsht_rsp_type table_apply(input tsht_req_type r);
      tsht_rsp_type res;
      int           pos;
      res.status       = ST_MISS;
      res.found_handle = '0;
      pos              = -1;
      case (r.op)
         OP_INSERT: begin
            if (tbl_fill >= TBL_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // ties go behind every entry with an equal stamp
               pos = 0;
               while (pos < tbl_fill && tbl_stamp[pos] >= r.stamp) pos++;
               for (int k = tbl_fill; k > pos; k--) begin
                  tbl_handle[k] = tbl_handle[k-1];
                  tbl_stamp[k]  = tbl_stamp[k-1];
                  tbl_tag[k]    = tbl_tag[k-1];
               end
               tbl_handle[pos] = r.handle;
               tbl_stamp[pos]  = r.stamp;
               tbl_tag[pos]    = r.name_tag;
               tbl_fill++;
               res.status = ST_OK;
            end
         end
         OP_DELETE: begin
            for (int i = 0; i < tbl_fill; i++)
               if (pos < 0 && tbl_handle[i] == r.handle) pos = i;
            if (pos >= 0) begin
               // close the gap
               for (int k = pos; k + 1 < tbl_fill; k++) begin
                  tbl_handle[k] = tbl_handle[k+1];
                  tbl_stamp[k]  = tbl_stamp[k+1];
                  tbl_tag[k]    = tbl_tag[k+1];
               end
               tbl_fill--;
               res.status = ST_OK;
            end
         end
         OP_LOOKUP: begin
            for (int i = 0; i < tbl_fill; i++)
               if (pos < 0 && tbl_tag[i] == r.name_tag) pos = i;
            if (pos >= 0) begin
               res.status       = ST_OK;
               res.found_handle = tbl_handle[pos];
            end
         end
         default: ;
      endcase
      res.entry_total = TOTAL_BITS'(tbl_fill);
      return res;
   endfunction

   function automatic tsht_req_type make_req(input logic [1:0] op,
                                             input logic [HANDLE_BITS-1:0] h,
                                             input logic [31:0] s,
                                             input logic [31:0] t);
      tsht_req_type r;
      r.op       = op;
      r.handle   = h;
      r.stamp    = s;
      r.name_tag = t;
      return r;
   endfunction

   // Random request: small pools for hits and ties, full-range values for bit coverage
   function automatic tsht_req_type random_request();
      tsht_req_type r;
      int           pick;
      int           ins_weight;
      pick       = $urandom_range(0, 99);
      ins_weight = (tbl_fill < 4) ? 60 : (tbl_fill > 13) ? 30 : 45;
      r.handle   = ($urandom_range(0, 3) == 0) ? HANDLE_BITS'($urandom)
                                               : HANDLE_BITS'($urandom_range(0, 31));
      r.stamp    = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
      r.name_tag = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
      if (pick < 3) begin
         r.op = OP_UNUSED;
      end else if (pick < 3 + ins_weight) begin
         r.op = OP_INSERT;
      end else if (pick < 3 + ins_weight + (97 - ins_weight) / 2) begin
         r.op = OP_DELETE;
         if (tbl_fill > 0 && $urandom_range(0, 3) != 0)
            r.handle = tbl_handle[$urandom_range(0, tbl_fill - 1)];
      end else begin
         r.op = OP_LOOKUP;
         if (tbl_fill > 0 && $urandom_range(0, 9) < 7)
            r.name_tag = tbl_tag[$urandom_range(0, tbl_fill - 1)];
      end
      return r;
   endfunction

   // Drive one request at the falling edge, hold it until the core takes it
   task automatic send_request(input tsht_req_type r);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = r;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(table_apply(r));
      request_count++;
   endtask

   // Hold the sender until every outstanding response has come back
   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_request(make_req(OP_LOOKUP, 16'h0000, 32'h0, 32'h0000_0000));
      send_request(make_req(OP_DELETE, 16'h0000, 32'h0, 32'h0));
      send_request(make_req(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(make_req(OP_INSERT, 16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF));
      send_request(make_req(OP_INSERT, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0000));
      // equal stamps must keep arrival order
      send_request(make_req(OP_INSERT, 16'h0001, 32'h5, 32'hAAAA_5555));
      send_request(make_req(OP_INSERT, 16'h0002, 32'h5, 32'hAAAA_5555));
      send_request(make_req(OP_INSERT, 16'h0003, 32'h5, 32'h5555_AAAA));
      // duplicate handle, tied with the newest entry
      send_request(make_req(OP_INSERT, 16'h0001, 32'hFFFF_FFFF, 32'h1234_5678));
      send_request(make_req(OP_LOOKUP, 16'h0, 32'h0, 32'hAAAA_5555));
      send_request(make_req(OP_LOOKUP, 16'h0, 32'h0, 32'hFFFF_FFFF));
      send_request(make_req(OP_LOOKUP, 16'h0, 32'h0, 32'h0000_0000));
      send_request(make_req(OP_LOOKUP, 16'h0, 32'h0, 32'hDEAD_BEEF));
      send_request(make_req(OP_DELETE, 16'h0001, 32'h0, 32'h0));
      send_request(make_req(OP_LOOKUP, 16'h0, 32'h0, 32'h1234_5678));
      send_request(make_req(OP_DELETE, 16'h0001, 32'h0, 32'h0));
      send_request(make_req(OP_LOOKUP, 16'h0, 32'h0, 32'hAAAA_5555));
      send_request(make_req(OP_UNUSED, 16'h0002, 32'h0, 32'hAAAA_5555));
      send_request(make_req(OP_DELETE, 16'h0007, 32'h0, 32'h0));
      send_request(make_req(OP_DELETE, 16'hFFFF, 32'h0, 32'h0));
      send_request(make_req(OP_DELETE, 16'h0000, 32'h0, 32'h0));
   endtask

   // Fill past capacity, look up every held tag, then delete everything
   task automatic test_fill_and_drain();
      tsht_req_type r;
      repeat (TBL_DEPTH + 2) begin
         r    = random_request();
         r.op = OP_INSERT;
         if ($urandom_range(0, 1) == 0) r.stamp = 32'($urandom_range(0, 7));
         send_request(r);
      end
      for (int i = 0; i < tbl_fill; i++)
         send_request(make_req(OP_LOOKUP, 16'h0, 32'h0, tbl_tag[i]));
      while (tbl_fill > 0)
         send_request(make_req(OP_DELETE, tbl_handle[$urandom_range(0, tbl_fill - 1)],
                               $urandom, $urandom));
      send_request(make_req(OP_DELETE, 16'($urandom), 32'h0, 32'h0));
   endtask

   task automatic test_random_mix(input int count);
      for (int n = 0; n < count; n++) begin
         // switch idling on and off in stretches, pause now and then
         if (n % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (n % 200 == 199) drain_responses();
         send_request(random_request());
      end
   endtask

   task automatic test_quiet_tail(input int count);
      idle_on = 1'b0;
      repeat (count) send_request(random_request());
   endtask

   // Stall the response side in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (idle_on && !reset && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_stall  = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      tsht_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("%0t: response with nothing expected: %p", $realtime, rsp_payload);
         end else begin
            want = pending_rsp.pop_front();
            case (want.status)
               ST_OK:   ok_count++;
               ST_FULL: full_count++;
               default: miss_count++;
            endcase
            if (rsp_payload.status !== want.status ||
                rsp_payload.found_handle !== want.found_handle ||
                rsp_payload.entry_total !== want.entry_total) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("%0t: mismatch status %0d/%0d handle %h/%h total %0d/%0d (exp/act)",
                           $realtime, want.status, rsp_payload.status, want.found_handle,
                           rsp_payload.found_handle, want.entry_total,
                           rsp_payload.entry_total);
            end
         end
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      drain_responses();
      test_fill_and_drain();
      drain_responses();
      test_random_mix(1200);
      drain_responses();
      test_fill_and_drain();
      test_quiet_tail(400);
      drain_responses();
      repeat (40) @(posedge clock);
      $display("%0d requests: %0d ok, %0d table full, %0d not found; %0d failures",
               request_count, ok_count, full_count, miss_count, fail_count);
      if (fail_count == 0 && pending_rsp.size() == 0)
         $display("timestamp_sorted_handle_table_core_tb: done, clean");
      else
         $display("timestamp_sorted_handle_table_core_tb: done, errors");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("timed out with %0d responses outstanding", pending_rsp.size());
      $display("timestamp_sorted_handle_table_core_tb: done, errors");
      $finish;
   end

endmodule

// ===== timestamp_sorted_handle_table_core.f =====
hw/rtl/tsht_pkg.sv
hw/rtl/tsht_ram.sv
hw/rtl/tsht_seq.sv
hw/rtl/timestamp_sorted_handle_table_core.sv
bench/timestamp_sorted_handle_table_core_tb.sv
